### design/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the pll divider solver.
// ----------------------------------------------------------------------------
package pds_pkg;

    // fixed field widths
    localparam int TW  = 29;   // target frequency
    localparam int WW  = 32;   // pll register word
    localparam int DW  = 27;   // reference clock
    localparam int FBW = 12;   // full feedback divider

    // frequency bands
    localparam logic [TW-1:0] BAND_LOW  = 29'd50000000;
    localparam logic [TW-1:0] BAND_MID1 = 29'd100000000;
    localparam logic [TW-1:0] BAND_MID2 = 29'd200000000;
    localparam logic [TW-1:0] BAND_HIGH = 29'd400000000;

    // feedback divider limits
    localparam int unsigned FB_MIN = 52;
    localparam int unsigned FB_MAX = 400;
    localparam int unsigned FB_SAT = 4095;

    // output divider codes
    localparam logic [1:0] OD_LOW  = 2'd3;
    localparam logic [1:0] OD_MID  = 2'd2;
    localparam logic [1:0] OD_HIGH = 2'd1;
    localparam logic [1:0] OD_NONE = 2'd0;

    localparam logic [DW-1:0] REF_CLK_RESET = 27'd12000000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT
    } t_state;

    // divider status toward the controller
    typedef struct packed {
        logic done;
        logic exact;
    } t_div_status;

endpackage

### design/pds_divider.sv
// ----------------------------------------------------------------------------
// pds_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pds_divider #(
    parameter int PW = 36
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PW-1:0]             i_dividend,
    input  logic [pds_pkg::DW-1:0]    i_divisor,
    output pds_pkg::t_div_status      o_status,
    output logic [PW-1:0]             o_quotient
);
    import pds_pkg::*;

    localparam int CW = (PW > 1) ? $clog2(PW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [PW-1:0] r_dq;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_dq[PW-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(PW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out, quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[PW-2:0], ge};
        end
    end

    assign o_status.done  = r_done;
    assign o_status.exact = (r_rem == '0);
    assign o_quotient     = r_dq;

endmodule

### design/pll_divider_solver.sv
// An out-of-band target is answered without a division; otherwise the result follows
// up to REF_DIV_LAST serial divisions (PW = 31 + clog2(REF_DIV_LAST+2), 34 by
// default).
// One transaction at a time: for an in-band target, busy stays high until the result strobe.
// The receiver cannot stall; each result is shown for one cycle.
// Reset: idle, no strobe, reference clock register at 12 MHz.
// ----------------------------------------------------------------------------
// pll_divider_solver
// Chooses output, reference and feedback dividers for a target frequency.
// ----------------------------------------------------------------------------
module pll_divider_solver #(
    parameter int REF_DIV_LAST = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pds_pkg::DW-1:0]   i_cfg_data,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [pds_pkg::TW-1:0]   i_target_hz,
    input  logic [pds_pkg::WW-1:0]   i_current_word,
    output logic                     o_valid,
    output logic [pds_pkg::WW-1:0]   o_new_word,
    output logic [pds_pkg::FBW-1:0]  o_feedback_full,
    output logic [1:0]               o_output_div,
    output logic [2:0]               o_reference_div,
    output logic                     o_odd_feedback,
    output logic                     o_search_failed,
    output logic                     o_feedback_too_high,
    output logic                     o_band_error
);
    import pds_pkg::*;

    localparam int RW = $clog2(REF_DIV_LAST + 2);
    localparam int SW = TW + 2;
    localparam int PW = SW + RW;

    t_state           r_state, n_state;
    logic [DW-1:0]    r_ref_clk;
    logic [SW-1:0]    r_step;
    logic [PW-1:0]    r_prod;
    logic [WW-1:0]    r_word;
    logic [1:0]       r_od;
    logic [RW-1:0]    r_ref;
    logic             r_first;
    logic             r_below;

    logic             r_valid;
    logic [WW-1:0]    r_new_word;
    logic [FBW-1:0]   r_fb;
    logic [1:0]       r_odiv;
    logic [2:0]       r_rdiv;
    logic             r_odd;
    logic             r_fail;
    logic             r_high;
    logic             r_berr;

    logic             accept;
    logic [1:0]       od;
    logic             band_err;
    logic [SW-1:0]    step;
    logic [DW-1:0]    divisor;
    logic             div_start;
    t_div_status      div_st;
    logic [PW-1:0]    q;

    logic             q_lt_min, q_le_max, start_search, below_eff;
    logic             found, at_last, finish_direct, finish, failed;
    logic [RW-1:0]    ref_out;
    logic [4:0]       ref_field;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clk <= REF_CLK_RESET;
        end else if (i_cfg_we) begin
            r_ref_clk <= i_cfg_data;
        end
    end

    assign divisor = (r_ref_clk == '0) ? DW'(1) : r_ref_clk;

    // band decode of the incoming target
    always_comb begin
        band_err = 1'b0;
        if (i_target_hz >= BAND_LOW && i_target_hz < BAND_MID1) begin
            od = OD_LOW;
        end else if (i_target_hz >= BAND_MID1 && i_target_hz < BAND_MID2) begin
            od = OD_MID;
        end else if (i_target_hz >= BAND_MID2 && i_target_hz <= BAND_HIGH) begin
            od = OD_HIGH;
        end else begin
            od       = OD_NONE;
            band_err = 1'b1;
        end
        step = SW'(i_target_hz) * SW'(od);
    end

    assign accept = i_start && !o_busy;

    // serial divider
    pds_divider #(
        .PW (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (divisor),
        .o_status   (div_st),
        .o_quotient (q)
    );

    // evaluation of one division result
    always_comb begin
        q_lt_min      = q < PW'(FB_MIN);
        q_le_max      = q <= PW'(FB_MAX);
        start_search  = q_lt_min || (q_le_max && !div_st.exact);
        below_eff     = r_first ? q_lt_min : r_below;
        found         = !q_lt_min && (below_eff || q_le_max) && div_st.exact && !q[0];
        at_last       = (r_ref == RW'(REF_DIV_LAST));
        finish_direct = r_first && !start_search;
        finish        = finish_direct || found || at_last;
        failed        = !finish_direct && !found && at_last;
        ref_out       = failed ? RW'(REF_DIV_LAST + 1) : r_ref;
        ref_field     = 5'(ref_out);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !band_err) n_state = S_LAUNCH;
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_st.done) n_state = finish ? S_IDLE : S_LAUNCH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            S_IDLE: begin
                o_busy    = 1'b0;
                div_start = 1'b0;
            end
            S_LAUNCH: begin
                o_busy    = 1'b1;
                div_start = 1'b1;
            end
            default: begin
                o_busy    = 1'b1;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step  <= step;
            r_prod  <= PW'({step, 1'b0});
            r_word  <= i_current_word;
            r_od    <= od;
            r_ref   <= RW'(2);
            r_first <= 1'b1;
            r_below <= 1'b0;
        end else if (r_state == S_WAIT && div_st.done && !finish) begin
            r_prod  <= r_first ? r_prod : r_prod + PW'(r_step);
            r_ref   <= r_first ? r_ref : r_ref + RW'(1);
            r_first <= 1'b0;
            r_below <= below_eff;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (accept && band_err) || (r_state == S_WAIT && div_st.done && finish);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (accept && band_err) begin
            r_new_word <= i_current_word;
            r_fb       <= '0;
            r_odiv     <= OD_NONE;
            r_rdiv     <= '0;
            r_odd      <= 1'b0;
            r_fail     <= 1'b0;
            r_high     <= 1'b0;
            r_berr     <= 1'b1;
        end else if (r_state == S_WAIT && div_st.done && finish) begin
            r_new_word <= {q[8:1], r_word[23:18], r_od, r_word[15:13], ref_field,
                           r_word[7:0]};
            r_fb       <= (q > PW'(FB_SAT)) ? FBW'(FB_SAT) : q[FBW-1:0];
            r_odiv     <= r_od;
            r_rdiv     <= 3'(ref_out);
            r_odd      <= q[0];
            r_fail     <= failed;
            r_high     <= finish_direct && !q_le_max;
            r_berr     <= 1'b0;
        end
    end

    assign o_valid             = r_valid;
    assign o_new_word          = r_new_word;
    assign o_feedback_full     = r_fb;
    assign o_output_div        = r_odiv;
    assign o_reference_div     = r_rdiv;
    assign o_odd_feedback      = r_odd;
    assign o_search_failed     = r_fail;
    assign o_feedback_too_high = r_high;
    assign o_band_error        = r_berr;

`ifndef SYNTH
    // a result is only issued once the search has released the block
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    // an in-band transaction always starts a division
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !band_err) |=> (r_state == S_LAUNCH))
        else $error("in-band transaction did not launch a division");

    // divider completion only while waiting on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == S_WAIT))
        else $error("divider finished outside wait state");

    // an exhausted search reports the divider past the last one
    a_fail_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_search_failed) |-> (o_reference_div == 3'(REF_DIV_LAST + 1)))
        else $error("failed search with wrong reference divider");
`endif

endmodule
